// ===== sv/phit_pkg.sv =====
// Shared types, sizes and codes for the polygon region hit test block.
package phit_pkg;

  // Store sizes
  localparam int MAX_REGIONS  = 64;
  localparam int MAX_VERTICES = 512;

  localparam int REG_AW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int VTX_AW = $clog2(MAX_VERTICES);
  localparam int RCNT_W = $clog2(MAX_REGIONS + 1);
  localparam int VCNT_W = $clog2(MAX_VERTICES + 1);

  // Field widths
  localparam int CMD_W   = 2;
  localparam int COORD_W = 16;
  localparam int TAG_W   = 10;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;

  // Smallest region that is tested
  localparam int MIN_EDGES = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_OPEN   = 2'd1,
    CMD_VERTEX = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } vertex_t;

  typedef struct packed {
    logic [VTX_AW-1:0] first;
    logic [VCNT_W-1:0] count;
    logic [TAG_W-1:0]  tag;
  } region_rec_t;

  // Request to the shared edge unit
  typedef struct packed {
    logic    start;
    vertex_t cur;
    vertex_t prev;
    vertex_t pt;
  } edge_req_t;

  typedef struct packed {
    logic done;
    logic crossing;
  } edge_res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REG_RD,
    S_REG_CHK,
    S_V_PREV,
    S_V_CUR,
    S_EDGE,
    S_V_RD,
    S_DONE
  } seq_state_t;

  typedef enum logic [1:0] {
    E_IDLE,
    E_MUL_A,
    E_MUL_B,
    E_CMP
  } edge_state_t;

endpackage

// ===== sv/phit_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module phit_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/phit_edge.sv =====
// Shared edge unit: one multiplier works out the crossing test of one polygon edge.
module phit_edge
  import phit_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  edge_req_t req,
  output edge_res_t res
);

  edge_state_t state, state_next;

  logic signed [DIFF_W-1:0] da, dy, dx, dq;
  logic                     straddle;
  logic signed [PROD_W-1:0] prod, lhs;
  logic signed [DIFF_W-1:0] op_a, op_b;
  logic signed [PROD_W-1:0] prod_next;
  logic                     less, more;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Operand select for the one multiplier
  always_comb begin
    op_a = da;
    op_b = dy;
    if (state == E_MUL_B) begin
      op_a = dx;
      op_b = dq;
    end
  end

  assign prod_next = PROD_W'(op_a) * PROD_W'(op_b);
  assign less      = (lhs < prod);
  assign more      = (lhs > prod);

  // Next state and result
  always_comb begin
    state_next   = state;
    res.done     = 1'b0;
    res.crossing = 1'b0;
    unique case (state)
      E_IDLE: begin
        if (req.start) begin
          state_next = E_MUL_A;
        end
      end
      E_MUL_A: begin
        state_next = E_MUL_B;
      end
      E_MUL_B: begin
        state_next = E_CMP;
      end
      E_CMP: begin
        res.done     = 1'b1;
        // rising edge: query x left when lhs < rhs; falling edge turns it round
        res.crossing = straddle & (dy[DIFF_W-1] ? more : less);
        state_next   = E_IDLE;
      end
      default: begin
        state_next = E_IDLE;
      end
    endcase
  end

  // Operand latch and product registers
  always_ff @(posedge clk) begin
    if (state == E_IDLE && req.start) begin
      da       <= DIFF_W'(req.pt.x) - DIFF_W'(req.cur.x);
      dy       <= DIFF_W'(req.prev.y) - DIFF_W'(req.cur.y);
      dx       <= DIFF_W'(req.prev.x) - DIFF_W'(req.cur.x);
      dq       <= DIFF_W'(req.pt.y) - DIFF_W'(req.cur.y);
      straddle <= (req.cur.y > req.pt.y) != (req.prev.y > req.pt.y);
    end
    if (state == E_MUL_A || state == E_MUL_B) begin
      prod <= prod_next;
    end
    if (state == E_MUL_B) begin
      lhs <= prod;
    end
  end

`ifndef SYNTHESIS
  // a new edge is only started while the unit is free
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> state == E_IDLE)
    else $error("edge unit started while busy");

  // the result comes in the compare state, after the two multiply states
  a_done_lat: assert property (@(posedge clk) disable iff (rst)
    (req.start && state == E_IDLE) |-> ##3 res.done)
    else $error("edge result latency wrong");
`endif

endmodule

// ===== sv/polygon_region_hit_test.sv =====
// Top level of the polygon region hit test: command handling, query sequencer and stores.
//
// Input channel (in_valid / in_stall) takes one request per command: clear, open a region
// with a tag, append a vertex to the open region, or query a point. Clear, open and vertex
// requests give no result. A query walks the stored regions in order, and every edge of each
// region with three or more vertices, through one shared multiplier unit, and stops at the
// first region that holds the point. in_stall is high for the whole of a query. The output
// channel (out_valid / out_stall) carries hit, hit_tag and overflow from an output register;
// a stalled result holds, and clear, open and vertex requests are still taken meanwhile.
// A further query finishes its walk and then waits for the register. Reset empties the
// region and vertex lists and clears the overflow flag; the stores need no clearing pass
// since only written entries are ever read.
module polygon_region_hit_test
  import phit_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [CMD_W-1:0]          cmd,
  input  logic signed [COORD_W-1:0] point_x,
  input  logic signed [COORD_W-1:0] point_y,
  input  logic [TAG_W-1:0]          tag,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      hit,
  output logic [TAG_W-1:0]          hit_tag,
  output logic                      overflow
);

  seq_state_t state, state_next;

  // List bookkeeping
  logic [RCNT_W-1:0] region_total, region_total_next;
  logic [VCNT_W-1:0] vertex_total, vertex_total_next;
  logic              overflow_flag, overflow_flag_next;
  logic              region_open, region_open_next;
  logic [VTX_AW-1:0] open_first, open_first_next;
  logic [VCNT_W-1:0] open_count, open_count_next;
  logic [TAG_W-1:0]  open_tag, open_tag_next;

  // Query walk
  logic [RCNT_W-1:0] r_idx, r_idx_next;
  logic [VCNT_W-1:0] k, k_next;
  logic [VCNT_W-1:0] cnt, cnt_next;
  logic [VTX_AW-1:0] first, first_next;
  logic [TAG_W-1:0]  rtag, rtag_next;
  logic              parity, parity_next;
  vertex_t           prev, prev_next;
  vertex_t           cur, cur_next;
  vertex_t           qpt, qpt_next;
  logic              found, found_next;
  logic [TAG_W-1:0]  found_tag, found_tag_next;

  // Output register
  logic              out_valid_next;
  logic              hit_next;
  logic [TAG_W-1:0]  hit_tag_next;
  logic              overflow_next;

  // Store ports
  logic              vtx_we;
  logic [VTX_AW-1:0] vtx_waddr, vtx_raddr;
  vertex_t           vtx_wdata, vtx_rdata;
  logic              reg_we;
  logic [REG_AW-1:0] reg_waddr, reg_raddr;
  region_rec_t       reg_wdata, reg_rdata;

  edge_req_t         ereq;
  edge_res_t         eres;

  logic              in_fire, out_fire;
  cmd_t              cmd_c;
  logic              last_region, last_edge;

  assign in_stall = (state != S_IDLE);
  assign in_fire  = in_valid & ~in_stall;
  assign out_fire = out_valid & ~out_stall;
  assign cmd_c    = cmd_t'(cmd);

  assign last_region = (RCNT_W'(r_idx + 1'b1) >= region_total);
  assign last_edge   = (k == VCNT_W'(cnt - 1'b1));

  phit_ram #(
    .WIDTH ($bits(vertex_t)),
    .DEPTH (MAX_VERTICES)
  ) u_vtx_ram (
    .clk   (clk),
    .we    (vtx_we),
    .waddr (vtx_waddr),
    .wdata (vtx_wdata),
    .raddr (vtx_raddr),
    .rdata (vtx_rdata)
  );

  phit_ram #(
    .WIDTH ($bits(region_rec_t)),
    .DEPTH (MAX_REGIONS)
  ) u_reg_ram (
    .clk   (clk),
    .we    (reg_we),
    .waddr (reg_waddr),
    .wdata (reg_wdata),
    .raddr (reg_raddr),
    .rdata (reg_rdata)
  );

  phit_edge u_edge (
    .clk (clk),
    .rst (rst),
    .req (ereq),
    .res (eres)
  );

  // State and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      region_total  <= '0;
      vertex_total  <= '0;
      overflow_flag <= 1'b0;
      region_open   <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      region_total  <= region_total_next;
      vertex_total  <= vertex_total_next;
      overflow_flag <= overflow_flag_next;
      region_open   <= region_open_next;
      out_valid     <= out_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    open_first <= open_first_next;
    open_count <= open_count_next;
    open_tag   <= open_tag_next;
    r_idx      <= r_idx_next;
    k          <= k_next;
    cnt        <= cnt_next;
    first      <= first_next;
    rtag       <= rtag_next;
    parity     <= parity_next;
    prev       <= prev_next;
    cur        <= cur_next;
    qpt        <= qpt_next;
    found      <= found_next;
    found_tag  <= found_tag_next;
    hit        <= hit_next;
    hit_tag    <= hit_tag_next;
    overflow   <= overflow_next;
  end

  // Sequencer: command handling and query walk
  always_comb begin
    state_next         = state;
    region_total_next  = region_total;
    vertex_total_next  = vertex_total;
    overflow_flag_next = overflow_flag;
    region_open_next   = region_open;
    open_first_next    = open_first;
    open_count_next    = open_count;
    open_tag_next      = open_tag;
    r_idx_next         = r_idx;
    k_next             = k;
    cnt_next           = cnt;
    first_next         = first;
    rtag_next          = rtag;
    parity_next        = parity;
    prev_next          = prev;
    cur_next           = cur;
    qpt_next           = qpt;
    found_next         = found;
    found_tag_next     = found_tag;
    out_valid_next     = out_valid & ~out_fire;
    hit_next           = hit;
    hit_tag_next       = hit_tag;
    overflow_next      = overflow;

    vtx_we    = 1'b0;
    vtx_waddr = vertex_total[VTX_AW-1:0];
    vtx_wdata = '{x: point_x, y: point_y};
    vtx_raddr = VTX_AW'(first + k[VTX_AW-1:0]);
    reg_we    = 1'b0;
    reg_waddr = REG_AW'(region_total);
    reg_wdata = '{first: vertex_total[VTX_AW-1:0], count: '0, tag: tag};
    reg_raddr = r_idx[REG_AW-1:0];

    ereq.start = 1'b0;
    ereq.cur   = vtx_rdata;
    ereq.prev  = prev;
    ereq.pt    = qpt;

    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          unique case (cmd_c)
            CMD_CLEAR: begin
              region_total_next  = '0;
              vertex_total_next  = '0;
              overflow_flag_next = 1'b0;
              region_open_next   = 1'b0;
            end
            CMD_OPEN: begin
              if (region_total >= RCNT_W'(MAX_REGIONS)) begin
                overflow_flag_next = 1'b1;
                region_open_next   = 1'b0;
              end else begin
                reg_we            = 1'b1;
                open_first_next   = vertex_total[VTX_AW-1:0];
                open_count_next   = '0;
                open_tag_next     = tag;
                region_total_next = RCNT_W'(region_total + 1'b1);
                region_open_next  = 1'b1;
              end
            end
            CMD_VERTEX: begin
              if (region_open) begin
                if (vertex_total >= VCNT_W'(MAX_VERTICES)) begin
                  overflow_flag_next = 1'b1;
                end else begin
                  // store vertex and rewrite the open region's record with the new count
                  vtx_we            = 1'b1;
                  vertex_total_next = VCNT_W'(vertex_total + 1'b1);
                  open_count_next   = VCNT_W'(open_count + 1'b1);
                  reg_we            = 1'b1;
                  reg_waddr         = REG_AW'(region_total - 1'b1);
                  reg_wdata         = '{first: open_first, count: open_count_next,
                                        tag: open_tag};
                end
              end
            end
            CMD_QUERY: begin
              qpt_next   = '{x: point_x, y: point_y};
              r_idx_next = '0;
              found_next = 1'b0;
              state_next = (region_total == '0) ? S_DONE : S_REG_RD;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_REG_RD: begin
        state_next = S_REG_CHK;
      end
      S_REG_CHK: begin
        first_next  = reg_rdata.first;
        cnt_next    = reg_rdata.count;
        rtag_next   = reg_rdata.tag;
        k_next      = '0;
        parity_next = 1'b0;
        if (reg_rdata.count < VCNT_W'(MIN_EDGES)) begin
          // small region: skip
          if (last_region) begin
            state_next = S_DONE;
          end else begin
            r_idx_next = RCNT_W'(r_idx + 1'b1);
            state_next = S_REG_RD;
          end
        end else begin
          // fetch the closing vertex first
          vtx_raddr  = VTX_AW'(VCNT_W'(reg_rdata.first) + reg_rdata.count - 1'b1);
          state_next = S_V_PREV;
        end
      end
      S_V_PREV: begin
        prev_next  = vtx_rdata;
        state_next = S_V_CUR;
      end
      S_V_CUR: begin
        cur_next   = vtx_rdata;
        ereq.start = 1'b1;
        state_next = S_EDGE;
      end
      S_EDGE: begin
        if (eres.done) begin
          parity_next = parity ^ eres.crossing;
          prev_next   = cur;
          if (last_edge) begin
            if (parity ^ eres.crossing) begin
              found_next     = 1'b1;
              found_tag_next = rtag;
              state_next     = S_DONE;
            end else if (last_region) begin
              state_next = S_DONE;
            end else begin
              r_idx_next = RCNT_W'(r_idx + 1'b1);
              state_next = S_REG_RD;
            end
          end else begin
            k_next     = VCNT_W'(k + 1'b1);
            state_next = S_V_RD;
          end
        end
      end
      S_V_RD: begin
        state_next = S_V_CUR;
      end
      S_DONE: begin
        // load the output register once it is free
        if (!out_valid || out_fire) begin
          out_valid_next = 1'b1;
          hit_next       = found;
          hit_tag_next   = found ? found_tag : '0;
          overflow_next  = overflow_flag;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_vtx_bound: assert property (@(posedge clk) disable iff (rst)
    vertex_total <= VCNT_W'(MAX_VERTICES))
    else $error("vertex count past store size");

  a_open_has_region: assert property (@(posedge clk) disable iff (rst)
    region_open |-> region_total != '0)
    else $error("open region with empty region list");

  a_query_starts: assert property (@(posedge clk) disable iff (rst)
    (in_fire && cmd_c == CMD_QUERY) |=> (state == S_REG_RD || state == S_DONE))
    else $error("query did not start its walk");

  a_edge_free: assert property (@(posedge clk) disable iff (rst)
    state == S_V_CUR |-> !eres.done)
    else $error("edge unit still busy at a new edge");
`endif

endmodule
